FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PIDAW_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pidaw assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PIDAW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pidaw assertion failed");

`endif

FILE: hw/rtl/pidaw_pkg.sv
`default_nettype none

package pidaw_pkg;

	// configuration register indexes
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KP_GAIN          = 3'd0,
		REG_KI_GAIN          = 3'd1,
		REG_KD_GAIN          = 3'd2,
		REG_P_ON_MEASUREMENT = 3'd3,
		REG_OUT_MIN          = 3'd4,
		REG_OUT_MAX          = 3'd5
	} reg_idx_t;

	// upper output limit after reset
	localparam int RESET_OUT_MAX = 255;

	// news of a limit write, registered in the cycle after the write
	typedef struct packed {
		logic limit_written;  // a limit was written while in auto
		logic limits_ordered; // out_min < out_max for the current pair
	} lim_evt_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pidaw_cfg.sv
`default_nettype none

module pidaw_cfg #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int GAIN_WIDTH   = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [pidaw_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [((GAIN_WIDTH > SAMPLE_WIDTH) ? GAIN_WIDTH : SAMPLE_WIDTH)-1:0] cfg_data,
	input  logic                                 auto_active,
	output logic signed [GAIN_WIDTH-1:0]         kp_gain,
	output logic signed [GAIN_WIDTH-1:0]         ki_gain,
	output logic signed [GAIN_WIDTH-1:0]         kd_gain,
	output logic                                 p_on_measurement,
	output logic signed [SAMPLE_WIDTH-1:0]       out_min,
	output logic signed [SAMPLE_WIDTH-1:0]       out_max,
	output pidaw_pkg::lim_evt_t                  lim_evt
);

	localparam logic signed [SAMPLE_WIDTH-1:0] RST_MAX = SAMPLE_WIDTH'(pidaw_pkg::RESET_OUT_MAX);

	logic signed [GAIN_WIDTH-1:0]   kp_q, ki_q, kd_q;
	logic                           pom_q;
	logic signed [SAMPLE_WIDTH-1:0] min_q, max_q;
	logic signed [SAMPLE_WIDTH-1:0] new_min, new_max;
	logic                           lim_wr;
	logic                           written_q, ordered_q;

	// limit pair as it stands after this write
	always_comb begin
		new_min = min_q;
		new_max = max_q;
		lim_wr  = 1'b0;
		if (cfg_write) begin
			if (cfg_index == pidaw_pkg::REG_OUT_MIN) begin
				new_min = signed'(cfg_data[SAMPLE_WIDTH-1:0]);
				lim_wr  = 1'b1;
			end
			if (cfg_index == pidaw_pkg::REG_OUT_MAX) begin
				new_max = signed'(cfg_data[SAMPLE_WIDTH-1:0]);
				lim_wr  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= '0;
			ki_q      <= '0;
			kd_q      <= '0;
			pom_q     <= 1'b0;
			min_q     <= '0;
			max_q     <= RST_MAX;
			written_q <= 1'b0;
			ordered_q <= (RST_MAX > SAMPLE_WIDTH'(0));
		end else begin
			written_q <= lim_wr && auto_active;
			if (lim_wr) begin
				ordered_q <= (new_min < new_max);
			end
			if (cfg_write) begin
				unique case (pidaw_pkg::reg_idx_t'(cfg_index))
					pidaw_pkg::REG_KP_GAIN:          kp_q  <= signed'(cfg_data[GAIN_WIDTH-1:0]);
					pidaw_pkg::REG_KI_GAIN:          ki_q  <= signed'(cfg_data[GAIN_WIDTH-1:0]);
					pidaw_pkg::REG_KD_GAIN:          kd_q  <= signed'(cfg_data[GAIN_WIDTH-1:0]);
					pidaw_pkg::REG_P_ON_MEASUREMENT: pom_q <= cfg_data[0];
					pidaw_pkg::REG_OUT_MIN:          min_q <= new_min;
					pidaw_pkg::REG_OUT_MAX:          max_q <= new_max;
					default: ;
				endcase
			end
		end
	end

	assign kp_gain                = kp_q;
	assign ki_gain                = ki_q;
	assign kd_gain                = kd_q;
	assign p_on_measurement       = pom_q;
	assign out_min                = min_q;
	assign out_max                = max_q;
	assign lim_evt.limit_written  = written_q;
	assign lim_evt.limits_ordered = ordered_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pid_controller_antiwindup.sv
// PID controller with integral clamp anti-windup. Each transaction on the item
// channel is one elapsed sample period (measurement, setpoint, manual drive and
// auto-enable) and gives exactly one transaction on the result channel, in
// order. Gains are signed Q8.GAIN_FRAC_BITS, the integral is kept at
// SAMPLE_WIDTH+GAIN_FRAC_BITS bits; in auto the drive is the clamped output
// floored to an integer, in manual the manual drive. Throughput is one sample
// per clock cycle sustained while the result channel accepts; an item passes
// the input stage, multiplier stage, sum stage, integral stage and output
// register, held only while the result channel stalls. The integral recursion
// closes inside the integral stage, one add and one clamp per cycle.
// Configuration writes are registered and must only be issued while no sample
// is in flight; an ordered limit write in auto re-clamps the integral.
`default_nettype none

module pid_controller_antiwindup #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_write,
	input  logic [pidaw_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [((GAIN_FRAC_BITS + 8 > SAMPLE_WIDTH) ? GAIN_FRAC_BITS + 8 : SAMPLE_WIDTH)-1:0]
	                                            cfg_data,
	// sample items
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]      measured,
	input  logic signed [SAMPLE_WIDTH-1:0]      setpoint,
	input  logic signed [SAMPLE_WIDTH-1:0]      manual_output,
	input  logic                                auto_enable,
	// results
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      drive,
	output logic                                in_auto
);

	localparam int GW   = GAIN_FRAC_BITS + 8;          // gain width
	localparam int DW   = SAMPLE_WIDTH + 1;            // error and measurement change
	localparam int PW   = GW + DW;                     // exact product
	localparam int SUMW = PW + 1;                      // difference of two products
	localparam int IW   = SAMPLE_WIDTH + GAIN_FRAC_BITS; // clamped integral
	localparam int AW   = SUMW + 1;                    // integral plus update

	// configuration
	logic signed [GW-1:0]           kp, ki, kd;
	logic                           pom;
	logic signed [SAMPLE_WIDTH-1:0] out_min, out_max;
	pidaw_pkg::lim_evt_t            lim_evt;

	// controller state
	logic                           auto_active_q;
	logic signed [SAMPLE_WIDTH-1:0] prev_meas_q;
	logic signed [IW-1:0]           integral_q;

	// per-stage valid and load enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, result_valid_q;
	logic take_out, mv4, mv3, mv2, mv1;
	logic item_acc;

	// stage payloads
	logic signed [DW-1:0]           err_s1, dmeas_s1;
	logic signed [SAMPLE_WIDTH-1:0] manual_s1, manual_s2, manual_s3, manual_s4;
	logic                           auto_s1, auto_s2, auto_s3, auto_s4;
	logic                           entry_s1, entry_s2, entry_s3;
	logic signed [PW-1:0]           kp_err_s2, ki_err_s2, kp_dm_s2, kd_dm_s2;
	logic signed [SAMPLE_WIDTH-1:0] man_lim_s2, man_lim_s3;
	logic signed [SUMW-1:0]         delta_s3, pd_s3, pd_s4;
	logic signed [IW-1:0]           integ_s4;
	logic signed [SAMPLE_WIDTH-1:0] drive_q;
	logic                           in_auto_q;

	// combinational helpers
	logic signed [DW-1:0]           err_in, dmeas_in;
	logic signed [SAMPLE_WIDTH-1:0] man_lim;
	logic signed [SUMW-1:0]         delta_nx, pd_nx;
	logic signed [IW-1:0]           lo_i, hi_i, base_i, int_nx, int_cfg;
	logic signed [AW-1:0]           acc_sum, y_sum, y_cl;

	pidaw_cfg #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.GAIN_WIDTH   (GW)
	) u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.auto_active      (auto_active_q),
		.kp_gain          (kp),
		.ki_gain          (ki),
		.kd_gain          (kd),
		.p_on_measurement (pom),
		.out_min          (out_min),
		.out_max          (out_max),
		.lim_evt          (lim_evt)
	);

	// a stage loads when it is empty or its occupant moves on
	assign take_out   = !result_valid_q || result_ready;
	assign mv4        = !valid_s4 || take_out;
	assign mv3        = !valid_s3 || mv4;
	assign mv2        = !valid_s2 || mv3;
	assign mv1        = !valid_s1 || mv2;
	assign item_ready = mv1;
	assign item_acc   = item_valid && mv1;

	// limits scaled to the integral format
	assign lo_i = {out_min, {GAIN_FRAC_BITS{1'b0}}};
	assign hi_i = {out_max, {GAIN_FRAC_BITS{1'b0}}};

	// input stage: error and measurement change; zero change on auto entry
	always_comb begin
		err_in   = DW'(setpoint) - DW'(measured);
		dmeas_in = '0;
		if (auto_active_q) begin
			dmeas_in = DW'(measured) - DW'(prev_meas_q);
		end
	end

	// manual value clamped for bumpless auto entry, upper bound tested first
	always_comb begin
		man_lim = manual_s1;
		if (manual_s1 > out_max) begin
			man_lim = out_max;
		end else if (manual_s1 < out_min) begin
			man_lim = out_min;
		end
	end

	// integral update and proportional-derivative terms
	always_comb begin
		delta_nx = SUMW'(ki_err_s2);
		pd_nx    = -SUMW'(kd_dm_s2);
		if (pom) begin
			delta_nx = SUMW'(ki_err_s2) - SUMW'(kp_dm_s2);
		end else begin
			pd_nx = SUMW'(kp_err_s2) - SUMW'(kd_dm_s2);
		end
	end

	// anti-windup: integral clamped to the output limits
	always_comb begin
		base_i = integral_q;
		if (entry_s3) begin
			base_i = {man_lim_s3, {GAIN_FRAC_BITS{1'b0}}};
		end
		acc_sum = AW'(base_i) + AW'(delta_s3);
		int_nx  = acc_sum[IW-1:0];
		if (acc_sum > AW'(hi_i)) begin
			int_nx = hi_i;
		end else if (acc_sum < AW'(lo_i)) begin
			int_nx = lo_i;
		end
	end

	// re-clamp after a limit write in auto
	always_comb begin
		int_cfg = integral_q;
		if (integral_q > hi_i) begin
			int_cfg = hi_i;
		end else if (integral_q < lo_i) begin
			int_cfg = lo_i;
		end
	end

	// output sum and clamp; the floor is the integer bits of the clamped value
	always_comb begin
		y_sum = AW'(integ_s4) + AW'(pd_s4);
		y_cl  = y_sum;
		if (y_sum > AW'(hi_i)) begin
			y_cl = AW'(hi_i);
		end else if (y_sum < AW'(lo_i)) begin
			y_cl = AW'(lo_i);
		end
	end

	// controller state and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_active_q  <= 1'b0;
			prev_meas_q    <= '0;
			integral_q     <= '0;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			valid_s4       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_acc) begin
				auto_active_q <= auto_enable;
				if (auto_enable) begin
					prev_meas_q <= measured;
				end
			end
			if (valid_s3 && mv4 && auto_s3) begin
				integral_q <= int_nx;
			end else if (lim_evt.limit_written && lim_evt.limits_ordered) begin
				integral_q <= int_cfg;
			end
			if (mv1) begin
				valid_s1 <= item_valid;
			end
			if (mv2) begin
				valid_s2 <= valid_s1;
			end
			if (mv3) begin
				valid_s3 <= valid_s2;
			end
			if (mv4) begin
				valid_s4 <= valid_s3;
			end
			if (take_out) begin
				result_valid_q <= valid_s4;
			end
		end
	end

	// stage payloads, no reset
	always_ff @(posedge clk) begin
		if (item_acc) begin
			err_s1    <= err_in;
			dmeas_s1  <= dmeas_in;
			manual_s1 <= manual_output;
			auto_s1   <= auto_enable;
			entry_s1  <= auto_enable && !auto_active_q;
		end
		// multiplier stage
		if (valid_s1 && mv2) begin
			kp_err_s2  <= PW'(kp) * PW'(err_s1);
			ki_err_s2  <= PW'(ki) * PW'(err_s1);
			kp_dm_s2   <= PW'(kp) * PW'(dmeas_s1);
			kd_dm_s2   <= PW'(kd) * PW'(dmeas_s1);
			man_lim_s2 <= man_lim;
			manual_s2  <= manual_s1;
			auto_s2    <= auto_s1;
			entry_s2   <= entry_s1;
		end
		// sum stage
		if (valid_s2 && mv3) begin
			delta_s3   <= delta_nx;
			pd_s3      <= pd_nx;
			man_lim_s3 <= man_lim_s2;
			manual_s3  <= manual_s2;
			auto_s3    <= auto_s2;
			entry_s3   <= entry_s2;
		end
		// integral stage
		if (valid_s3 && mv4) begin
			integ_s4  <= int_nx;
			pd_s4     <= pd_s3;
			manual_s4 <= manual_s3;
			auto_s4   <= auto_s3;
		end
		// output register
		if (valid_s4 && take_out) begin
			in_auto_q <= auto_s4;
			drive_q   <= auto_s4 ? y_cl[GAIN_FRAC_BITS +: SAMPLE_WIDTH] : manual_s4;
		end
	end

	assign result_valid = result_valid_q;
	assign drive        = drive_q;
	assign in_auto      = in_auto_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pidaw_checker.sv
`default_nettype none

`include "assert_macros.svh"

module pidaw_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           item_valid,
	input wire logic                           item_ready,
	input wire logic signed [SAMPLE_WIDTH-1:0] manual_output,
	input wire logic                           auto_enable,
	input wire logic                           result_valid,
	input wire logic                           result_ready,
	input wire logic signed [SAMPLE_WIDTH-1:0] drive,
	input wire logic                           in_auto
);

	logic       item_acc;
	logic [2:0] up_q;  // edges since reset release, saturating

	assign item_acc = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q <= '0;
		end else if (up_q != 3'd7) begin
			up_q <= up_q + 3'd1;
		end
	end

	// output stalled: transaction held
	`PIDAW_ASSERT_NEXT(a_hold_valid, clk, arst_n, result_valid && !result_ready, result_valid)
	`PIDAW_ASSERT_NEXT(a_hold_data, clk, arst_n, result_valid && !result_ready,
		$stable(drive) && $stable(in_auto))

	// an empty output register never back-pressures the input
	`PIDAW_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !result_valid, item_ready)

	// no stall while the item passes the stages: it shows up at the output with its mode
	`PIDAW_ASSERT_IMPL(a_latency_mode, clk, arst_n,
		(up_q >= 3'd5) && $past(item_acc, 5) && $past(result_ready, 1) && $past(result_ready, 2) && $past(result_ready, 3) && $past(result_ready, 4),
		result_valid && (in_auto == $past(auto_enable, 5)))

	// manual samples pass straight through
	`PIDAW_ASSERT_IMPL(a_manual_pass, clk, arst_n,
		(up_q >= 3'd5) && $past(item_acc, 5) && !$past(auto_enable, 5) && $past(result_ready, 1) && $past(result_ready, 2) && $past(result_ready, 3) && $past(result_ready, 4),
		result_valid && (drive == $past(manual_output, 5)))

endmodule

bind pid_controller_antiwindup pidaw_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_pidaw_checker (.*);

`default_nettype wire
